@@ design/sprite_frame_sequencer_top_defines.svh @@
// Assertion macros for the sprite frame sequencer checker.
`ifndef SPRITE_FRAME_SEQUENCER_TOP_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SFS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SFS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sfs_pkg.sv @@
// Shared request/response types and codes for the sprite frame sequencer.
package sfs_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FRAME  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] MODE_LOOP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] entity;
    logic [8:0]  frame_total;
    logic [15:0] frame_period;
    logic [1:0]  play_mode;
    logic [15:0] target_id;
    logic [15:0] elapsed_ms;
  } sfs_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [15:0] anim_id;
    logic [15:0] out_entity;
    logic [7:0]  frame_index;
    logic        last;
  } sfs_rsp_t;

endpackage

@@ design/sprite_frame_sequencer_top.sv @@
// Sprite frame sequencer: channel table walked by one slot sequencer over a slot memory.
// Add: reply registered from the add state. Remove: valid slots read and ids compared
// (free slots skipped) until one matches, then the remove reply. Tick: valid slots read,
// summed, checked, stepped (a once channel that ends is freed at the check), free slots
// skipped, then the done reply. One request in flight, next taken in the cycle after the last
// response loads; rsp stalls hold the walk. Sync rst clears slot valid, next id, rsp_valid.
module sprite_frame_sequencer_top import sfs_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int MAX_FRAMES = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  sfs_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output sfs_rsp_t rsp
);

  localparam int         PW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [8:0] MAX_CNT = 9'(MAX_FRAMES);
  localparam logic [PW-1:0] LAST_SLOT = PW'(CHANNELS - 1);

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] entity;
    logic [8:0]  count;
    logic [15:0] period;
    logic [1:0]  mode;
    logic [31:0] accum;
    logic [9:0]  frame;
    logic        rising;
  } slot_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ADD  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_CMP  = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_STEP = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  slot_t mem [CHANNELS];
  slot_t rd_data;
  slot_t wr_data;
  logic          wr_en;
  logic [PW-1:0] wr_addr;

  state_t        state, state_next;
  logic [PW-1:0] ptr, ptr_next;
  logic          found, found_next;
  sfs_req_t      req_q;
  logic [32:0]   sum_q, sum_next;
  logic [31:0]   acc_q, acc_next;
  logic [9:0]    frm_q, frm_next;
  logic          ris_q, ris_next;
  logic [15:0]   next_id, next_id_next;
  logic [CHANNELS-1:0] slot_valid, slot_valid_next;
  logic          rsp_load;
  sfs_rsp_t      rsp_data;

  logic          rsp_free;
  logic          last_slot;
  logic          any_free;
  logic [PW-1:0] free_idx;
  logic [8:0]    cnt_in;
  logic signed [9:0] top;
  logic          ge;
  logic          gt;
  logic [9:0]    frm_step;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign last_slot = (ptr == LAST_SLOT);
  assign any_free  = !(&slot_valid);

  always_comb begin
    free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = PW'(i);
    end
  end

  assign cnt_in = (req_q.frame_total == 9'd0) ? 9'd1 :
                  (req_q.frame_total > MAX_CNT) ? MAX_CNT : req_q.frame_total;
  assign top = $signed({1'b0, rd_data.count}) - 10'sd1;
  assign ge  = (sum_q >= {17'd0, rd_data.period});
  assign gt  = (acc_q > {16'd0, rd_data.period});

  always_comb begin
    frm_step = frm_q;
    if (ris_q) begin
      if ($signed(frm_q) < top) frm_step = frm_q + 10'd1;
    end else begin
      if ($signed(frm_q) > 10'sd0) frm_step = frm_q - 10'd1;
    end
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    found_next      = found;
    sum_next        = sum_q;
    acc_next        = acc_q;
    frm_next        = frm_q;
    ris_next        = ris_q;
    next_id_next    = next_id;
    slot_valid_next = slot_valid;
    rsp_load        = 1'b0;
    rsp_data        = '0;
    wr_en           = 1'b0;
    wr_addr         = ptr;
    wr_data         = rd_data;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ptr_next   = '0;
          found_next = 1'b0;
          case (req.op)
            OP_ADD:              state_next = S_ADD;
            OP_REMOVE, OP_TICK:  state_next = S_RD;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (rsp_free) begin
          rsp_load      = 1'b1;
          rsp_data.kind = KIND_ADD;
          rsp_data.last = 1'b1;
          if (any_free) begin
            wr_en          = 1'b1;
            wr_addr        = free_idx;
            wr_data.id     = next_id;
            wr_data.entity = req_q.entity;
            wr_data.count  = cnt_in;
            wr_data.period = req_q.frame_period;
            wr_data.mode   = req_q.play_mode;
            wr_data.accum  = '0;
            wr_data.frame  = '0;
            wr_data.rising = 1'b1;
            slot_valid_next[free_idx] = 1'b1;
            rsp_data.ok      = 1'b1;
            rsp_data.anim_id = next_id;
            next_id_next     = next_id + 16'd1;
          end
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        if (slot_valid[ptr]) begin
          state_next = (req_q.op == OP_REMOVE) ? S_CMP : S_SUM;
        end else if (last_slot) begin
          state_next = S_FIN;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_CMP: begin
        if (rd_data.id == req_q.target_id) begin
          slot_valid_next[ptr] = 1'b0;
          found_next           = 1'b1;
          state_next           = S_FIN;
        end else if (last_slot) begin
          state_next = S_FIN;
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = S_RD;
        end
      end
      S_SUM: begin
        sum_next   = {1'b0, rd_data.accum} + {17'd0, req_q.elapsed_ms};
        state_next = S_CHK;
      end
      S_CHK: begin
        acc_next   = sum_q[32] ? 32'hFFFF_FFFF : sum_q[31:0];
        frm_next   = rd_data.frame;
        ris_next   = rd_data.rising;
        state_next = S_STEP;
        if (($signed(rd_data.frame) == top) && rd_data.rising && ge) begin
          if (rd_data.mode == MODE_LOOP) begin
            frm_next = 10'h3FF;
          end else if (rd_data.mode == MODE_PINGPONG) begin
            ris_next = 1'b0;
          end else begin
            slot_valid_next[ptr] = 1'b0;
            if (last_slot) begin
              state_next = S_FIN;
            end else begin
              ptr_next   = ptr + 1'b1;
              state_next = S_RD;
            end
          end
        end else if ((rd_data.frame == 10'd0) && !rd_data.rising && ge) begin
          ris_next = 1'b1;
        end
      end
      S_STEP: begin
        if (!gt || rsp_free) begin
          wr_en          = 1'b1;
          wr_data.accum  = gt ? (acc_q - {16'd0, rd_data.period}) : acc_q;
          wr_data.frame  = gt ? frm_step : frm_q;
          wr_data.rising = ris_q;
          if (gt) begin
            rsp_load             = 1'b1;
            rsp_data.kind        = KIND_FRAME;
            rsp_data.ok          = 1'b1;
            rsp_data.anim_id     = rd_data.id;
            rsp_data.out_entity  = rd_data.entity;
            rsp_data.frame_index = frm_step[7:0];
          end
          if (last_slot) begin
            state_next = S_FIN;
          end else begin
            ptr_next   = ptr + 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_FIN: begin
        if (rsp_free) begin
          rsp_load      = 1'b1;
          rsp_data.last = 1'b1;
          if (req_q.op == OP_REMOVE) begin
            rsp_data.kind    = KIND_REMOVE;
            rsp_data.ok      = found;
            rsp_data.anim_id = req_q.target_id;
          end else begin
            rsp_data.kind = KIND_DONE;
            rsp_data.ok   = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      next_id    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      next_id    <= next_id_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    found <= found_next;
    sum_q <= sum_next;
    acc_q <= acc_next;
    frm_q <= frm_next;
    ris_q <= ris_next;
    if (req_valid && req_ready) req_q <= req;
    if (rsp_load) rsp <= rsp_data;
  end

endmodule

@@ design/sfs_checker.sv @@
// Port-level checker for the sprite frame sequencer, bound to the top level.
`include "sprite_frame_sequencer_top_defines.svh"

module sfs_port_checker import sfs_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input sfs_req_t req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input sfs_rsp_t rsp
);

  logic req_take;
  logic op_known;
  logic rsp_stall;
  logic rsp_frame;
  logic rsp_reply;
  logic frame_shape;
  logic reply_shape;

  assign req_take    = req_valid && req_ready;
  assign op_known    = (req.op == OP_ADD) || (req.op == OP_REMOVE) || (req.op == OP_TICK);
  assign rsp_stall   = rsp_valid && !rsp_ready;
  assign rsp_frame   = rsp_valid && (rsp.kind == KIND_FRAME);
  assign rsp_reply   = rsp_valid && (rsp.kind != KIND_FRAME);
  assign frame_shape = !rsp.last && rsp.ok && !req_ready;
  assign reply_shape = rsp.last && (rsp.out_entity == 16'd0) && (rsp.frame_index == 8'd0);

  `SFS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")
  `SFS_ASSERT_NEXT(a_busy_after_req, req_take && op_known, !req_ready, "ready high after a request")
  `SFS_ASSERT_SAME(a_frame_mid_tick, rsp_frame, frame_shape, "frame change outside a tick")
  `SFS_ASSERT_SAME(a_reply_last, rsp_reply, reply_shape, "reply not last or carries frame data")

endmodule

bind sprite_frame_sequencer_top sfs_port_checker u_sfs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
